### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset-qualified
`define MMM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmm assertion failed");

// next-cycle implication, reset-qualified
`define MMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmm assertion failed");

`endif

### rtl/mmm_pkg.sv
// shared types, constants and helper function of the montgomery multiplier
`timescale 1ns / 1ps

package mmm_pkg;

    // fixed field widths
    localparam int HALF_W      = 64;
    localparam int FULL_W      = 128;
    localparam int CFG_INDEX_W = 8;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS_HIGH = 8'd1;

    // reset values of the modulus registers
    localparam logic [HALF_W-1:0] MODULUS_LOW_RST  = 64'h1;
    localparam logic [HALF_W-1:0] MODULUS_HIGH_RST = 64'h0;

    // bit-length search scans this many bits per cycle
    localparam int CHUNK       = 16;
    localparam int CHUNK_CNT_W = $clog2(CHUNK + 1);

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic det_step;
        logic precomp;
        logic round;
        logic final_wr;
    } mmm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic det_done;
        logic rounds_done;
    } mmm_sts_t;

    // bit length of one chunk, 0 for zero
    function automatic logic [CHUNK_CNT_W-1:0] chunk_bits(input logic [CHUNK-1:0] v);
        logic [CHUNK_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK; i++)
        begin
            if (v[i])
            begin
                n = CHUNK_CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

### rtl/mmm_if.sv
// valid/ready channel interfaces for operands, product and configuration
`timescale 1ns / 1ps

interface mmm_in_if import mmm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] x_low;
    logic [HALF_W-1:0] x_high;
    logic [HALF_W-1:0] y_low;
    logic [HALF_W-1:0] y_high;

    modport source (output valid, output x_low, output x_high, output y_low,
                    output y_high, input ready);
    modport sink   (input valid, input x_low, input x_high, input y_low,
                    input y_high, output ready);
endinterface

interface mmm_out_if import mmm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] product_low;
    logic [HALF_W-1:0] product_high;

    modport source (output valid, output product_low, output product_high, input ready);
    modport sink   (input valid, input product_low, input product_high, output ready);
endinterface

interface mmm_cfg_if import mmm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [HALF_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/mmm_datapath.sv
// montgomery datapath: operand registers, bit-length search, shared adder
`timescale 1ns / 1ps

module mmm_datapath import mmm_pkg::*; #(
    parameter int OPERAND_WIDTH = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mmm_cmd_t                 cmd,
    output mmm_sts_t                 sts,
    input  logic [OPERAND_WIDTH-1:0] in_x,
    input  logic [OPERAND_WIDTH-1:0] in_y,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output logic [OPERAND_WIDTH-1:0] prod
);

    localparam int W     = OPERAND_WIDTH;
    localparam int AW    = W + 2;
    localparam int NCH   = (W + CHUNK - 1) / CHUNK;
    localparam int PAD   = NCH * CHUNK;
    localparam int CNT_W = $clog2(PAD + 1);

    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W:0]       ym_reg;
    logic [W:0]       acc_reg;
    logic [W-1:0]     prod_reg;
    logic [PAD-1:0]   det_reg;
    logic [CNT_W-1:0] base_reg;
    logic [CNT_W-1:0] rnd_reg;

    logic [CHUNK-1:0] top_chunk;
    logic             top_hit;
    logic             last_chunk;
    logic             xi;
    logic             q;
    logic [W:0]       addend;
    logic [AW-1:0]    add_a;
    logic [AW-1:0]    add_b;
    logic             add_cin;
    logic [AW:0]      add_sum;
    logic [PAD-1:0]   or_word;

    // bit-length search looks at the top chunk of the or of all operands
    assign top_chunk  = det_reg[PAD-1 -: CHUNK];
    assign top_hit    = (top_chunk != '0);
    assign last_chunk = (base_reg == CNT_W'(CHUNK));

    always_comb
    begin
        or_word = '0;
        or_word[W-1:0] = in_x | in_y | modulus;
    end

    // round: pick the addend from x bit and parity correction
    assign xi = x_reg[0];
    assign q  = acc_reg[0] ^ (xi & y_reg[0]);

    always_comb
    begin
        case ({xi, q})
            2'b10:   addend = {1'b0, y_reg};
            2'b01:   addend = {1'b0, modulus};
            2'b11:   addend = ym_reg;
            default: addend = '0;
        endcase
    end

    // shared adder: y + m precompute, round sum, final acc - m
    always_comb
    begin
        add_a   = {1'b0, acc_reg};
        add_b   = {1'b0, addend};
        add_cin = 1'b0;
        if (cmd.precomp)
        begin
            add_a = {2'b00, y_reg};
            add_b = {2'b00, modulus};
        end
        if (cmd.final_wr)
        begin
            add_b   = ~{2'b00, modulus};
            add_cin = 1'b1;
        end
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{AW{1'b0}}, add_cin};

    // status back to the controller
    assign sts.det_done    = top_hit || last_chunk;
    assign sts.rounds_done = (rnd_reg == '0);

    // search and round counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            rnd_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                base_reg <= CNT_W'(PAD);
            end
            else if (cmd.det_step)
            begin
                if (top_hit)
                begin
                    rnd_reg <= base_reg - CNT_W'(CHUNK) + CNT_W'(chunk_bits(top_chunk));
                end
                else if (last_chunk)
                begin
                    rnd_reg <= '0;
                end
                else
                begin
                    base_reg <= base_reg - CNT_W'(CHUNK);
                end
            end
            else if (cmd.round)
            begin
                rnd_reg <= rnd_reg - CNT_W'(1);
            end
        end
    end

    // operand, accumulator and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= in_x;
            y_reg   <= in_y;
            acc_reg <= '0;
            det_reg <= or_word;
        end
        if (cmd.det_step && !top_hit)
        begin
            det_reg <= det_reg << CHUNK;
        end
        if (cmd.precomp)
        begin
            ym_reg <= add_sum[W:0];
        end
        if (cmd.round)
        begin
            acc_reg <= add_sum[W+1:1];
            x_reg   <= x_reg >> 1;
        end
        if (cmd.final_wr)
        begin
            prod_reg <= add_sum[AW] ? add_sum[W-1:0] : acc_reg[W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/mmm_ctrl.sv
// montgomery controller: sequencing state machine and output valid
`timescale 1ns / 1ps

module mmm_ctrl import mmm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output mmm_cmd_t cmd,
    input  mmm_sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_DETECT  = 5'b00010,
        S_PRECOMP = 5'b00100,
        S_ROUND   = 5'b01000,
        S_FINAL   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DETECT;
                end
            end
            S_DETECT:
            begin
                cmd.det_step = 1'b1;
                if (sts.det_done)
                begin
                    state_next = S_PRECOMP;
                end
            end
            S_PRECOMP:
            begin
                cmd.precomp = 1'b1;
                state_next  = S_ROUND;
            end
            S_ROUND:
            begin
                if (sts.rounds_done)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.round = 1'b1;
                end
            end
            S_FINAL:
            begin
                if (slot_free)
                begin
                    cmd.final_wr = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word held until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.final_wr)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/montgomery_modular_multiplier.sv
// Radix-2 Montgomery multiplier: product = X*Y*2^-n mod M, n the largest bit length of
// M, X and Y. One operand word at a time: after acceptance the block finds n (16 bits
// scanned per cycle), forms Y+M, runs the rounds and then a conditional subtraction,
// all on a single OPERAND_WIDTH+2 bit adder; the next word is taken once the block is
// back in idle. The round loop sets the rate. The finished product waits in an output
// register, so a new word is accepted while the previous product is still unread; the
// subtraction step of that new word then waits until the older product is taken.
// The user must write the modulus registers only while idle; the block itself does not
// enforce this.
`timescale 1ns / 1ps

module montgomery_modular_multiplier import mmm_pkg::*; #(
    parameter int OPERAND_WIDTH = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    mmm_cfg_if.sink   cfg,
    mmm_in_if.sink    operands,
    mmm_out_if.source result
);

    localparam int W = OPERAND_WIDTH;

    logic [HALF_W-1:0] mod_low_reg;
    logic [HALF_W-1:0] mod_high_reg;
    logic [FULL_W-1:0] x_full;
    logic [FULL_W-1:0] y_full;
    logic [FULL_W-1:0] m_full;
    logic [FULL_W-1:0] prod_full;
    logic [W-1:0]      prod;
    mmm_cmd_t          cmd;
    mmm_sts_t          sts;

    // modulus registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_low_reg  <= MODULUS_LOW_RST;
            mod_high_reg <= MODULUS_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODULUS_LOW:  mod_low_reg  <= cfg.data;
                REG_MODULUS_HIGH: mod_high_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // join halves, keep the datapath width
    assign x_full = {operands.x_high, operands.x_low};
    assign y_full = {operands.y_high, operands.y_low};
    assign m_full = {mod_high_reg, mod_low_reg};

    always_comb
    begin
        prod_full = '0;
        prod_full[W-1:0] = prod;
    end

    assign result.product_low  = prod_full[HALF_W-1:0];
    assign result.product_high = prod_full[FULL_W-1:HALF_W];

    mmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (operands.valid),
        .in_ready  (operands.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mmm_datapath #(
        .OPERAND_WIDTH (W)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .in_x    (x_full[W-1:0]),
        .in_y    (y_full[W-1:0]),
        .modulus (m_full[W-1:0]),
        .prod    (prod)
    );

endmodule

### rtl/mmm_checker.sv
// port-level checks of the montgomery multiplier and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmm_checker import mmm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [HALF_W-1:0] product_low,
    input logic [HALF_W-1:0] product_high
);

    logic in_acc;
    logic out_stall;

    assign in_acc    = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // a stalled product stays offered and unchanged
    `MMM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)
    `MMM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(product_low) && $stable(product_high))

    // one word at a time: busy right after an accept
    `MMM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !in_ready)

    // a product never shows up the cycle after an accept
    `MMM_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_acc, !$rose(out_valid))

endmodule

bind montgomery_modular_multiplier mmm_checker u_mmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (operands.valid),
    .in_ready     (operands.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .product_low  (result.product_low),
    .product_high (result.product_high)
);

### verif/tb.sv
// self-checking testbench of the montgomery modular multiplier: directed and random words
`timescale 1ns / 1ps

module tb;
    import mmm_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 8;
    localparam int DRAIN        = 200;
    localparam int IDLE_PCT     = 35;
    localparam int STEADY_FROM  = 700;
    localparam int STEADY_TO    = 1000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int REG_COUNT    = 2;
    localparam int MAX_REPORTS  = 40;
    localparam int NUM_PROBES   = 17;

    localparam logic [FULL_W-1:0] ALL_ONES     = {FULL_W{1'b1}};
    localparam logic [FULL_W-1:0] TOP_BIT      = {1'b1, 127'd0};
    localparam logic [FULL_W-1:0] TOP_PLUS_ONE = {1'b1, 126'd0, 1'b1};

    // one directed word: modulus in force, operands, and a hand-typed product if typed is set
    typedef struct packed {
        logic [FULL_W-1:0] modulus;
        logic [FULL_W-1:0] x;
        logic [FULL_W-1:0] y;
        logic              typed;
        logic [FULL_W-1:0] want;
    } probe_t;

    probe_t probes [NUM_PROBES] = '{
        // reset modulus of one
        '{128'd1, 128'd0, 128'd0, 1'b1, 128'd0},
        '{128'd1, 128'd1, 128'd1, 1'b1, 128'd0},
        '{128'd1, ALL_ONES, ALL_ONES, 1'b0, 128'd0},
        // full-width modulus, zero operand keeps the accumulator at zero
        '{ALL_ONES, 128'd0, ALL_ONES, 1'b1, 128'd0},
        '{ALL_ONES, ALL_ONES, 128'd0, 1'b1, 128'd0},
        '{ALL_ONES, ALL_ONES - 128'd1, ALL_ONES - 128'd1, 1'b0, 128'd0},
        '{ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, 128'd0},
        '{TOP_PLUS_ONE, TOP_BIT, TOP_BIT, 1'b0, 128'd0},
        '{TOP_PLUS_ONE, 128'd1, 128'd1, 1'b0, 128'd0},
        // zero modulus, all zero runs no rounds
        '{128'd0, 128'd0, 128'd0, 1'b1, 128'd0},
        '{128'd0, 128'd5, ALL_ONES, 1'b0, 128'd0},
        '{128'd0, ALL_ONES, 128'd1, 1'b0, 128'd0},
        // even moduli
        '{128'h1_0000_0000_0000_0000, 128'd3, 128'd7, 1'b0, 128'd0},
        '{ALL_ONES - 128'd1, ALL_ONES, ALL_ONES, 1'b0, 128'd0},
        // alternating patterns and half-boundary operands
        '{128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAB,
          128'h5555_5555_5555_5555_5555_5555_5555_5555,
          128'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA_AAAA, 1'b0, 128'd0},
        '{128'h0000_0000_0000_0000_FFFF_FFFF_FFFF_FFFF,
          128'h0000_0000_0000_0001_0000_0000_0000_0000,
          128'h0000_0000_0000_0000_8000_0000_0000_0001, 1'b0, 128'd0},
        '{128'd3, 128'd2, 128'd2, 1'b0, 128'd0}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mmm_cfg_if cfg_ch ();
    mmm_in_if  operand_ch ();
    mmm_out_if product_ch ();

    montgomery_modular_multiplier u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_ch),
        .operands (operand_ch),
        .result   (product_ch)
    );

    // modulus as the block should hold it, and products still owed
    logic [FULL_W-1:0] modulus = {MODULUS_HIGH_RST, MODULUS_LOW_RST};
    logic [FULL_W-1:0] expected_products [$];
    logic [FULL_W-1:0] want_product;
    int                errors        = 0;
    int                products_read = 0;
    int                cycle_count   = 0;
    bit                steady        = 1'b0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic int bit_len(input logic [FULL_W-1:0] v);
        int n;
        n = 0;
        for (int i = 0; i < FULL_W; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [FULL_W-1:0] low_mask(input int w);
        return (w >= FULL_W) ? ALL_ONES : ((128'd1 << w) - 128'd1);
    endfunction

    // bit-serial montgomery product x*y*2^-n mod m, two guard bits over the width
    function automatic logic [FULL_W-1:0] mont_product(input logic [FULL_W-1:0] x,
                                                      input logic [FULL_W-1:0] y,
                                                      input logic [FULL_W-1:0] m);
        logic [FULL_W+1:0] acc;
        logic [FULL_W+3:0] sum;
        int                n;
        n = bit_len(m);
        if (bit_len(x) > n)
        begin
            n = bit_len(x);
        end
        if (bit_len(y) > n)
        begin
            n = bit_len(y);
        end
        acc = '0;
        for (int i = 0; i < n; i++)
        begin
            sum = {2'b00, acc} + (x[i] ? {4'b0000, y} : '0);
            // parity correction keeps the halving exact
            if (sum[0])
            begin
                sum = sum + {4'b0000, m};
            end
            acc = sum[FULL_W+2:1];
        end
        if (acc[FULL_W+1:FULL_W] != 2'b00 || acc[FULL_W-1:0] >= m)
        begin
            acc = acc - {2'b00, m};
        end
        return acc[FULL_W-1:0];
    endfunction

    function automatic logic [FULL_W-1:0] rand_word();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic logic [FULL_W-1:0] pick_modulus();
        logic [FULL_W-1:0] m;
        case ($urandom_range(5))
            0: m = rand_word() | 128'd1;
            1: m = rand_word() | TOP_PLUS_ONE;
            2: m = (rand_word() & low_mask($urandom_range(1, 24))) | 128'd1;
            3:
            begin
                case ($urandom_range(3))
                    0: m = 128'd1;
                    1: m = ALL_ONES;
                    2: m = TOP_PLUS_ONE;
                    default: m = {64'd0, {64{1'b1}}};
                endcase
            end
            4: m = rand_word() & ~128'd1;
            default: m = '0;
        endcase
        return m;
    endfunction

    // mostly operands no wider than the modulus, some of random width, some edge values
    function automatic logic [FULL_W-1:0] pick_operand(input logic [FULL_W-1:0] m);
        int w;
        int roll;
        logic [FULL_W-1:0] v;
        roll = $urandom_range(99);
        if (roll < 65)
        begin
            w = bit_len(m);
            if (w == 0)
            begin
                w = $urandom_range(1, FULL_W);
            end
            v = rand_word() & low_mask(w);
        end
        else if (roll < 85)
        begin
            v = rand_word() & low_mask($urandom_range(1, FULL_W));
        end
        else
        begin
            case ($urandom_range(4))
                0: v = '0;
                1: v = 128'd1;
                2: v = ALL_ONES;
                3: v = m - 128'd1;
                default: v = m;
            endcase
        end
        return v;
    endfunction

    // one configuration write, mirrored once accepted
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [HALF_W-1:0] value);
        while (take_break())
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b0;
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_MODULUS_LOW:  modulus[HALF_W-1:0]      = value;
            REG_MODULUS_HIGH: modulus[FULL_W-1:HALF_W] = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // new modulus once the block has drained; optionally a write to an unused index
    task automatic set_modulus(input logic [FULL_W-1:0] m, input bit stray);
        bit high_first;
        high_first = $urandom_range(1);
        @(negedge clk);
        operand_ch.valid <= 1'b0;
        while (expected_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (stray)
        begin
            write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, 2 ** CFG_INDEX_W - 1)),
                      {$urandom, $urandom});
        end
        if (high_first)
        begin
            write_reg(REG_MODULUS_HIGH, m[FULL_W-1:HALF_W]);
            write_reg(REG_MODULUS_LOW, m[HALF_W-1:0]);
        end
        else
        begin
            write_reg(REG_MODULUS_LOW, m[HALF_W-1:0]);
            write_reg(REG_MODULUS_HIGH, m[FULL_W-1:HALF_W]);
        end
    endtask

    // offer one operand word, record its product when taken
    task automatic offer_operands(input logic [FULL_W-1:0] x, input logic [FULL_W-1:0] y,
                                  input logic [FULL_W-1:0] want);
        while (take_break())
        begin
            @(negedge clk);
            operand_ch.valid <= 1'b0;
        end
        @(negedge clk);
        operand_ch.valid  <= 1'b1;
        operand_ch.x_low  <= x[HALF_W-1:0];
        operand_ch.x_high <= x[FULL_W-1:HALF_W];
        operand_ch.y_low  <= y[HALF_W-1:0];
        operand_ch.y_high <= y[FULL_W-1:HALF_W];
        @(posedge clk);
        while (!operand_ch.ready)
        begin
            @(posedge clk);
        end
        expected_products.push_back(want);
    endtask

    // product side: random stalls plus one long hold-off to back the block up
    initial
    begin : product_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        product_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && products_read >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                product_ch.ready <= 1'b0;
            end
            else
            begin
                product_ch.ready <= !take_break();
            end
        end
    end

    // compare each product word with the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && product_ch.valid && product_ch.ready)
        begin
            if (expected_products.size() == 0)
            begin
                flag_error("product word arrived with none owed");
            end
            else
            begin
                want_product = expected_products.pop_front();
                if (product_ch.product_low !== want_product[HALF_W-1:0])
                begin
                    flag_error($sformatf("product_low got %h want %h",
                                         product_ch.product_low, want_product[HALF_W-1:0]));
                end
                if (product_ch.product_high !== want_product[FULL_W-1:HALF_W])
                begin
                    flag_error($sformatf("product_high got %h want %h",
                                         product_ch.product_high,
                                         want_product[FULL_W-1:HALF_W]));
                end
            end
            products_read++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("montgomery_modular_multiplier regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [FULL_W-1:0] m;
        logic [FULL_W-1:0] x;
        logic [FULL_W-1:0] y;
        int                sent;
        int                phase_len;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        operand_ch.valid  = 1'b0;
        operand_ch.x_low  = '0;
        operand_ch.x_high = '0;
        operand_ch.y_low  = '0;
        operand_ch.y_high = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words, modulus changed only where a row asks for another
        for (int r = 0; r < NUM_PROBES; r++)
        begin
            if (probes[r].modulus !== modulus)
            begin
                set_modulus(probes[r].modulus, 1'b1);
            end
            x = probes[r].x;
            y = probes[r].y;
            offer_operands(x, y, probes[r].typed ? probes[r].want : mont_product(x, y, modulus));
        end

        // random phases, each under its own modulus
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            m = pick_modulus();
            set_modulus(m, $urandom_range(2) == 0);
            phase_len = $urandom_range(60, 240);
            for (int j = 0; j < phase_len && sent < RANDOM_ITEMS; j++)
            begin
                steady = (sent >= STEADY_FROM && sent < STEADY_TO);
                x = pick_operand(modulus);
                y = pick_operand(modulus);
                offer_operands(x, y, mont_product(x, y, modulus));
                sent++;
            end
        end
        steady = 1'b0;

        // drain
        @(negedge clk);
        operand_ch.valid <= 1'b0;
        while (expected_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);
        if (expected_products.size() != 0)
        begin
            flag_error($sformatf("%0d product words never arrived", expected_products.size()));
        end
        if (errors == 0)
        begin
            $display("montgomery_modular_multiplier regression: pass");
        end
        else
        begin
            $display("montgomery_modular_multiplier regression: fail");
        end
        $finish;
    end

endmodule

### montgomery_modular_multiplier.f
+incdir+rtl
rtl/mmm_pkg.sv
rtl/mmm_if.sv
rtl/mmm_datapath.sv
rtl/mmm_ctrl.sv
rtl/montgomery_modular_multiplier.sv
rtl/mmm_checker.sv
verif/tb.sv
